// File: rtl/core/tlns_pkg.sv
// Package for the triggered LFSR noise sequencer: item types, register
// indexes, reset constants and the step ROM and lookup functions.
// No dependencies.
package tlns_pkg;

  // Result item (payload of the out_ channel)
  typedef struct packed {
    logic [7:0] level;
    logic       playing;
  } out_item_t;

  // Input item (payload of the in_ channel)
  typedef struct packed {
    logic [2:0] trigger_pins;
    logic       tick;
  } in_item_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE_RELOAD = 2'd0,
    REG_TICK_INTERVAL   = 2'd1,
    REG_NOISE_SEED      = 2'd2,
    REG_REST_LEVEL      = 2'd3
  } cfg_reg_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] debounce_reload;
    logic [15:0] tick_interval;
    logic [14:0] noise_seed;
    logic [7:0]  rest_level;
  } cfg_t;

  localparam logic [15:0] DEBOUNCE_RELOAD_RST = 16'd250;
  localparam logic [15:0] TICK_INTERVAL_RST   = 16'd375;
  localparam logic [14:0] NOISE_SEED_RST      = 15'h4000;
  localparam logic [7:0]  REST_LEVEL_RST      = 8'h80;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ROW_W      = 3;   // ROM row index, covers up to 8 sequences
  localparam int unsigned STEP_W     = 7;   // step counter width
  localparam int unsigned ROM_ROWS   = 2;   // rows holding data; others read zero
  localparam int unsigned ROM_COLS   = 64;

  // Step ROM: bits 3:0 hold exponent, 6:4 volume index, 7 long LFSR mode
  function automatic logic [7:0] rom_byte(input logic [ROW_W-1:0] row,
                                          input logic [STEP_W-1:0] col);
    logic [7:0] b;
    b = 8'h00;
    if (col < STEP_W'(ROM_COLS) && row < ROW_W'(ROM_ROWS)) begin
      unique case (row)
        3'd0: begin
          // falling volume, eight steps per level, long mode
          b = {1'b1, 3'd7 - col[5:3], 4'h0};
          if (col == 7'd63) b = 8'h8F;
        end
        3'd1: begin
          // alternating short/long mode blocks of sixteen steps
          b = {col[4], 3'd7, 4'h0};
          if (col == 7'd63) b = 8'hFF;
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // Hold period: 0, then 2^(e-1) passes
  function automatic logic [14:0] hold_len(input logic [3:0] e);
    logic [14:0] h;
    h = (e == 4'd0) ? 15'd0 : (15'd1 << (e - 4'd1));
    return h;
  endfunction

  localparam logic [7:0] VOL_MASK [8] = '{8'h00, 8'h01, 8'h03, 8'h07,
                                          8'h0F, 8'h1F, 8'h3F, 8'h7F};
  localparam logic [7:0] VOL_OFF  [8] = '{8'h80, 8'h7F, 8'h7E, 8'h7C,
                                          8'h78, 8'h70, 8'h60, 8'h40};

  // One shift of the noise register; feedback into bit 14 or bit 6
  function automatic logic [14:0] lfsr_shift(input logic [14:0] l, input logic long_m);
    logic [14:0] t;
    logic        fb;
    fb = l[0] ^ l[1];
    t  = l >> 1;
    if (long_m) t[14] = t[14] | fb;
    else        t[6]  = t[6] | fb;
    return t;
  endfunction

endpackage

// File: rtl/core/tlns_debounce.sv
// Trigger decode, clamp and debounce for the noise sequencer.
// Depends on tlns_pkg.
module tlns_debounce #(
  parameter int unsigned SEQ_COUNT = 3,
  parameter int unsigned SW        = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [2:0]    trigger_pins,
  input  logic [15:0]   debounce_reload,
  output logic [SW-1:0] stable_nxt
);
  import tlns_pkg::*;

  logic [15:0]   dl_r, dl_nxt, dl_dec;
  logic [SW-1:0] raw_last_r, raw_last_nxt;
  logic [SW-1:0] stable_r;
  logic [2:0]    trig_dec;
  logic [SW-1:0] trig;

  // active-low pins, clamp to the sequence count
  always_comb begin
    trig_dec = ~trigger_pins;
    if (trig_dec >= 3'(SEQ_COUNT)) trig = SW'(SEQ_COUNT);
    else                           trig = SW'(trig_dec);
  end

  // equal samples count down; a change reloads
  always_comb begin
    dl_nxt       = dl_r;
    raw_last_nxt = raw_last_r;
    stable_nxt   = stable_r;
    dl_dec       = dl_r - 16'd1;
    if (trig == raw_last_r) begin
      dl_nxt = dl_dec;
      if (dl_dec == 16'd0) begin
        stable_nxt = trig;
        dl_nxt     = debounce_reload;
      end
    end else begin
      raw_last_nxt = trig;
      dl_nxt       = debounce_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r       <= DEBOUNCE_RELOAD_RST;
      raw_last_r <= '0;
      stable_r   <= '0;
    end else if (en) begin
      dl_r       <= dl_nxt;
      raw_last_r <= raw_last_nxt;
      stable_r   <= stable_nxt;
    end
  end

endmodule

// File: rtl/core/tlns_seq.sv
// Sequencer and noise generator: tick counting, step ROM, hold counter,
// LFSR and output level. Depends on tlns_pkg.
module tlns_seq #(
  parameter int unsigned SEQ_STEPS = 64,
  parameter int unsigned SW        = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          tick,
  input  logic [SW-1:0] stable_trig,
  input  tlns_pkg::cfg_t cfg,
  output logic [7:0]    level_nxt,
  output logic          running_nxt
);
  import tlns_pkg::*;

  localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(SEQ_STEPS);
  localparam logic [STEP_W-1:0] STEP_PAST = STEP_W'(SEQ_STEPS + 1);

  logic [15:0]       tick_count_r, tick_count_nxt, tc_inc;
  logic [STEP_W-1:0] step_now_r, step_now_nxt;
  logic [STEP_W-1:0] step_seen_r, step_seen_nxt;
  logic              running_r;
  logic              noise_en_r, noise_en_nxt;
  logic [SW-1:0]     stable_last_r, stable_last_nxt;
  logic [SW-1:0]     sel_r, sel_nxt;
  logic [14:0]       hold_limit_r, hold_limit_nxt;
  logic [15:0]       hold_count_r, hold_count_nxt;
  logic [2:0]        vol_r, vol_nxt;
  logic              long_r, long_nxt;
  logic [14:0]       lfsr_r, lfsr_nxt;
  logic [7:0]        level_r;
  logic [7:0]        rb, off;

  always_comb begin
    tick_count_nxt  = tick_count_r;
    step_now_nxt    = step_now_r;
    step_seen_nxt   = step_seen_r;
    running_nxt     = running_r;
    noise_en_nxt    = noise_en_r;
    stable_last_nxt = stable_last_r;
    sel_nxt         = sel_r;
    hold_limit_nxt  = hold_limit_r;
    vol_nxt         = vol_r;
    long_nxt        = long_r;
    lfsr_nxt        = lfsr_r;
    level_nxt       = level_r;
    hold_count_nxt  = hold_count_r + 16'd1;
    tc_inc          = tick_count_r + 16'd1;
    rb              = 8'h00;
    off             = 8'h00;

    // tick counting, only while running
    if (running_r && tick) begin
      tick_count_nxt = tc_inc;
      if (tc_inc >= cfg.tick_interval) begin
        tick_count_nxt = '0;
        step_now_nxt   = step_now_r + STEP_W'(1);
      end
    end

    // new nonzero debounced trigger restarts a sequence
    if (stable_trig != stable_last_r) begin
      stable_last_nxt = stable_trig;
      if (stable_trig != '0) begin
        sel_nxt        = stable_trig - SW'(1);
        tick_count_nxt = '0;
        step_now_nxt   = '0;
        step_seen_nxt  = '0;
        noise_en_nxt   = 1'b1;
        running_nxt    = 1'b1;
      end
    end

    // step change: end of sequence or new ROM byte
    if (step_now_nxt != step_seen_nxt) begin
      if (step_now_nxt > STEP_END) begin
        hold_limit_nxt = '0;
        vol_nxt        = '0;
        long_nxt       = 1'b1;
        noise_en_nxt   = 1'b0;
        lfsr_nxt       = cfg.noise_seed;
        step_now_nxt   = STEP_PAST;
        running_nxt    = 1'b0;
      end
      step_seen_nxt = step_now_nxt;
      if (step_seen_nxt <= STEP_END && step_seen_nxt != '0) begin
        rb             = rom_byte(ROW_W'(sel_nxt), step_seen_nxt - STEP_W'(1));
        hold_limit_nxt = hold_len(rb[3:0]);
        vol_nxt        = rb[6:4];
        long_nxt       = rb[7];
      end
    end

    // noise hold period elapsed: shift the LFSR while noise is enabled and refresh the level
    if (hold_count_r > {1'b0, hold_limit_nxt}) begin
      if (noise_en_nxt) lfsr_nxt = lfsr_shift(lfsr_nxt, long_nxt);
      off            = (vol_nxt == 3'd0) ? cfg.rest_level : VOL_OFF[vol_nxt];
      level_nxt      = (lfsr_nxt[7:0] & VOL_MASK[vol_nxt]) + off;
      hold_count_nxt = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      step_now_r    <= '0;
      step_seen_r   <= '0;
      running_r     <= 1'b0;
      noise_en_r    <= 1'b0;
      stable_last_r <= '0;
      sel_r         <= '0;
      hold_limit_r  <= '0;
      hold_count_r  <= 16'd1;
      vol_r         <= '0;
      long_r        <= 1'b1;
      lfsr_r        <= NOISE_SEED_RST;
      level_r       <= REST_LEVEL_RST;
    end else if (en) begin
      tick_count_r  <= tick_count_nxt;
      step_now_r    <= step_now_nxt;
      step_seen_r   <= step_seen_nxt;
      running_r     <= running_nxt;
      noise_en_r    <= noise_en_nxt;
      stable_last_r <= stable_last_nxt;
      sel_r         <= sel_nxt;
      hold_limit_r  <= hold_limit_nxt;
      hold_count_r  <= hold_count_nxt;
      vol_r         <= vol_nxt;
      long_r        <= long_nxt;
      lfsr_r        <= lfsr_nxt;
      level_r       <= level_nxt;
    end
  end

endmodule

// File: rtl/core/triggered_lfsr_noise_sequencer_core.sv
// Top level of the triggered LFSR noise sequencer: handshakes, input and
// result registers, configuration registers. Uses tlns_pkg, tlns_debounce,
// tlns_seq.
//
//   channel  | direction | payload                     | handshake
//   in_      | input     | in_item_t  (pins, tick)     | in_valid / in_ready
//   out_     | output    | out_item_t (level, playing) | out_valid / out_ready
//   cfg_     | input     | cfg_index, cfg_data         | cfg_valid / cfg_ready
//
// An item is held in the input register; its result is computed in a single
// pass and written to the result register when that register is free or
// being drained; one item per cycle sustained while out_ready stays high.
// Synchronous active-low reset restores all but in_data_r and out_data_r.
// A stalled result holds the result register and, behind it, the input
// register; cfg_ready is always high.
module triggered_lfsr_noise_sequencer_core #(
  parameter int unsigned SEQ_COUNT = 3,
  parameter int unsigned SEQ_STEPS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlns_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlns_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tlns_pkg::cfg_reg_t  cfg_index,
  input  logic [tlns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlns_pkg::*;

  localparam int unsigned SW = $clog2(SEQ_COUNT + 1);

  in_item_t      in_data_r;
  logic          in_vld_r;
  out_item_t     out_data_r;
  logic          out_vld_r;
  logic          adv;
  cfg_t          cfg_r;
  logic [SW-1:0] stable_nxt;
  logic [7:0]    level_nxt;
  logic          running_nxt;

  // stage 2 fires when the input register holds an item and the result register is free or being drained
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_reload <= DEBOUNCE_RELOAD_RST;
      cfg_r.tick_interval   <= TICK_INTERVAL_RST;
      cfg_r.noise_seed      <= NOISE_SEED_RST;
      cfg_r.rest_level      <= REST_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE_RELOAD: cfg_r.debounce_reload <= cfg_data;
        REG_TICK_INTERVAL:   cfg_r.tick_interval   <= cfg_data;
        REG_NOISE_SEED:      cfg_r.noise_seed      <= cfg_data[14:0];
        REG_REST_LEVEL:      cfg_r.rest_level      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.level   <= level_nxt;
      out_data_r.playing <= running_nxt;
    end
  end

  tlns_debounce #(
    .SEQ_COUNT (SEQ_COUNT),
    .SW        (SW)
  ) u_debounce (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv),
    .trigger_pins    (in_data_r.trigger_pins),
    .debounce_reload (cfg_r.debounce_reload),
    .stable_nxt      (stable_nxt)
  );

  tlns_seq #(
    .SEQ_STEPS (SEQ_STEPS),
    .SW        (SW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .tick        (in_data_r.tick),
    .stable_trig (stable_nxt),
    .cfg         (cfg_r),
    .level_nxt   (level_nxt),
    .running_nxt (running_nxt)
  );

endmodule
